[rtl/core/lasm_pkg.sv]
// Package for the lidar angle segment mask block: sizes, codes, FSM states
// and the command and status structs between controller and datapath.
// Depends on nothing; used by every module in rtl/core.
`default_nettype none

package lasm_pkg;

    localparam int ANGLE_BITS       = 16;
    localparam int MAX_SEGMENTS     = 16;
    localparam int SEG_IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int MAX_SCAN_SAMPLES = 4096;
    localparam int TALLY_W          = $clog2(MAX_SCAN_SAMPLES + 1);
    localparam int RATIO_FRAC       = 16;
    localparam int RATIO_W          = RATIO_FRAC + 1;
    localparam int DIV_STEPS        = RATIO_W;
    localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX = 1'd1;

    localparam logic signed [ANGLE_BITS-1:0] WIN_MIN_RST = {1'b1, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS-1:0] WIN_MAX_RST = {1'b0, {(ANGLE_BITS-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_EVAL,
        S_SAMPLE_EVAL,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_DIV_START,
        S_DIV,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic rd_prev;
        logic push_commit;
        logic refuse;
        logic sample_read;
        logic sample_eval;
        logic search_init;
        logic rd_k;
        logic k_inc;
        logic take_k;
        logic set_nomore;
        logic div_init;
        logic div_step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                last;
        logic                ordered;
        logic                need_search;
        logic                k_end;
        logic                probe_hit;
        logic                div_last;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/core/lidar_angle_segment_mask_top.sv]
// Top level of the lidar angle segment mask block.
// Depends on lasm_pkg, lasm_controller and lasm_datapath.
//
// The block holds up to 16 angular segments in a small memory and masks
// scan samples against them one item at a time. A sample that is not the
// last of its scan and passes the current segment's end probes the later
// segments in turn until one qualifies or the table ends. The last sample
// of a scan runs the 17-step shift-subtract divider that forms the Q1.16
// mask ratio. A new item is taken once the previous one has reached the
// output register, and a result waits there until the downstream side
// lifts its stall. Configuration writes are always ready and must be
// issued while idle.
`default_nettype none

module lidar_angle_segment_mask_top (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_stall,
    input  wire logic [lasm_pkg::ACTION_W-1:0]           i_action,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_seg_start,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_seg_end,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_sample_angle,
    input  wire logic                                    i_last_sample,
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic [lasm_pkg::STATUS_W-1:0]                o_status,
    output logic                                         o_mask_bit,
    output logic                                         o_scan_done,
    output logic [lasm_pkg::TALLY_W-1:0]                 o_masked_count,
    output logic [lasm_pkg::RATIO_W-1:0]                 o_mask_ratio,
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [lasm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_cfg_data
);

    lasm_pkg::t_dp_cmd    dp_cmd;
    lasm_pkg::t_dp_status dp_sts;

    assign o_cfg_ready = 1'b1;

    lasm_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    lasm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_action       (i_action),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_sample_angle (i_sample_angle),
        .i_last_sample  (i_last_sample),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (o_status),
        .o_mask_bit     (o_mask_bit),
        .o_scan_done    (o_scan_done),
        .o_masked_count (o_masked_count),
        .o_mask_ratio   (o_mask_ratio)
    );

endmodule

`default_nettype wire

[rtl/core/lasm_datapath.sv]
// Datapath of the lidar angle segment mask: segment memory, scan state,
// tallies, the serial ratio divider and the result registers.
// Depends on lasm_pkg; driven by lasm_controller through t_dp_cmd.
`default_nettype none

module lasm_datapath (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire lasm_pkg::t_dp_cmd                       i_cmd,
    output lasm_pkg::t_dp_status                         o_sts,
    input  wire logic [lasm_pkg::ACTION_W-1:0]           i_action,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_seg_start,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_seg_end,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_sample_angle,
    input  wire logic                                    i_last_sample,
    input  wire logic                                    i_cfg_we,
    input  wire logic [lasm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_cfg_data,
    output logic [lasm_pkg::STATUS_W-1:0]                o_status,
    output logic                                         o_mask_bit,
    output logic                                         o_scan_done,
    output logic [lasm_pkg::TALLY_W-1:0]                 o_masked_count,
    output logic [lasm_pkg::RATIO_W-1:0]                 o_mask_ratio
);

    logic signed [lasm_pkg::ANGLE_BITS-1:0] mem_lo [lasm_pkg::MAX_SEGMENTS];
    logic signed [lasm_pkg::ANGLE_BITS-1:0] mem_hi [lasm_pkg::MAX_SEGMENTS];

    logic signed [lasm_pkg::ANGLE_BITS-1:0] r_win_min;
    logic signed [lasm_pkg::ANGLE_BITS-1:0] r_win_max;

    logic [lasm_pkg::ACTION_W-1:0]          r_in_action;
    logic signed [lasm_pkg::ANGLE_BITS-1:0] r_in_start;
    logic signed [lasm_pkg::ANGLE_BITS-1:0] r_in_end;
    logic signed [lasm_pkg::ANGLE_BITS-1:0] r_in_angle;
    logic                                   r_in_last;

    logic signed [lasm_pkg::ANGLE_BITS-1:0] r_rd_lo;
    logic signed [lasm_pkg::ANGLE_BITS-1:0] r_rd_hi;

    logic [lasm_pkg::SEG_CNT_W-1:0] r_seg_count;
    logic                           r_ordered;
    logic [lasm_pkg::SEG_IDX_W-1:0] r_ptr;
    logic                           r_nomore;
    logic                           r_in_scan;
    logic [lasm_pkg::TALLY_W-1:0]   r_masked;
    logic [lasm_pkg::TALLY_W-1:0]   r_sampled;
    logic [lasm_pkg::SEG_CNT_W-1:0] r_k;
    logic [lasm_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic [lasm_pkg::TALLY_W-1:0]   r_rem;
    logic [lasm_pkg::TALLY_W-1:0]   r_den;
    logic [lasm_pkg::RATIO_W-1:0]   r_quo;

    logic [lasm_pkg::STATUS_W-1:0]  r_res_status;
    logic                           r_res_mbit;
    logic                           r_res_done;
    logic [lasm_pkg::TALLY_W-1:0]   r_res_count;

    logic                           rd_en;
    logic [lasm_pkg::SEG_IDX_W-1:0] rd_addr;
    logic [lasm_pkg::SEG_CNT_W-1:0] cnt_m1;
    logic                           push_ok;
    logic                           ptr_valid;
    logic                           hit;
    logic [lasm_pkg::TALLY_W:0]     div_t;
    logic                           div_ge;

    assign cnt_m1    = r_seg_count - lasm_pkg::SEG_CNT_W'(1);
    assign ptr_valid = {1'b0, r_ptr} < r_seg_count;
    assign hit       = ptr_valid && (r_in_angle >= r_rd_lo) && (r_in_angle <= r_rd_hi);
    assign push_ok   = (r_in_start <= r_in_end) && (r_in_start >= r_win_min)
                    && (r_in_end <= r_win_max)
                    && (r_seg_count < lasm_pkg::SEG_CNT_W'(lasm_pkg::MAX_SEGMENTS));

    assign div_t  = (r_div_cnt == lasm_pkg::DIV_CNT_W'(lasm_pkg::DIV_STEPS))
                  ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign div_ge = div_t >= {1'b0, r_den};

    always_comb begin
        rd_en   = i_cmd.rd_prev || i_cmd.sample_read || i_cmd.rd_k;
        rd_addr = r_k[lasm_pkg::SEG_IDX_W-1:0];
        if (i_cmd.rd_prev) begin
            rd_addr = cnt_m1[lasm_pkg::SEG_IDX_W-1:0];
        end else if (i_cmd.sample_read) begin
            rd_addr = r_in_scan ? r_ptr : '0;
        end
    end

    always_comb begin
        o_sts.action      = r_in_action;
        o_sts.last        = r_in_last;
        o_sts.ordered     = r_ordered;
        o_sts.need_search = ptr_valid && !r_nomore && (r_in_angle > r_rd_hi);
        o_sts.k_end       = r_k >= r_seg_count;
        o_sts.probe_hit   = r_rd_lo >= r_in_angle;
        o_sts.div_last    = r_div_cnt == lasm_pkg::DIV_CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_commit && push_ok) begin
            mem_lo[r_seg_count[lasm_pkg::SEG_IDX_W-1:0]] <= r_in_start;
            mem_hi[r_seg_count[lasm_pkg::SEG_IDX_W-1:0]] <= r_in_end;
        end
        if (rd_en) begin
            r_rd_lo <= mem_lo[rd_addr];
            r_rd_hi <= mem_hi[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_min   <= lasm_pkg::WIN_MIN_RST;
            r_win_max   <= lasm_pkg::WIN_MAX_RST;
            r_seg_count <= '0;
            r_ordered   <= 1'b1;
            r_ptr       <= '0;
            r_nomore    <= 1'b0;
            r_in_scan   <= 1'b0;
            r_masked    <= '0;
            r_sampled   <= '0;
            r_k         <= '0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lasm_pkg::CFG_WIN_MIN: r_win_min <= i_cfg_data;
                    lasm_pkg::CFG_WIN_MAX: r_win_max <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_seg_count <= '0;
                r_ordered   <= 1'b1;
            end
            if (i_cmd.push_commit && push_ok) begin
                if ((r_seg_count != '0) && (r_rd_hi > r_in_start)) begin
                    r_ordered <= 1'b0;
                end
                r_seg_count <= r_seg_count + lasm_pkg::SEG_CNT_W'(1);
            end
            if (i_cmd.sample_read && !r_in_scan) begin
                r_in_scan <= 1'b1;
                r_ptr     <= '0;
                r_nomore  <= 1'b0;
                r_masked  <= '0;
                r_sampled <= '0;
            end
            if (i_cmd.sample_eval
                && (r_sampled < lasm_pkg::TALLY_W'(lasm_pkg::MAX_SCAN_SAMPLES))) begin
                r_sampled <= r_sampled + lasm_pkg::TALLY_W'(1);
                if (hit) begin
                    r_masked <= r_masked + lasm_pkg::TALLY_W'(1);
                end
            end
            if (i_cmd.search_init) begin
                r_k <= {1'b0, r_ptr} + lasm_pkg::SEG_CNT_W'(1);
            end
            if (i_cmd.k_inc) begin
                r_k <= r_k + lasm_pkg::SEG_CNT_W'(1);
            end
            if (i_cmd.take_k) begin
                r_ptr <= r_k[lasm_pkg::SEG_IDX_W-1:0];
            end
            if (i_cmd.set_nomore) begin
                r_nomore <= 1'b1;
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= lasm_pkg::DIV_CNT_W'(lasm_pkg::DIV_STEPS);
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - lasm_pkg::DIV_CNT_W'(1);
            end
            if (i_cmd.clear || i_cmd.div_init || (i_cmd.refuse && r_in_last)) begin
                r_in_scan <= 1'b0;
                r_ptr     <= '0;
                r_nomore  <= 1'b0;
                r_masked  <= '0;
                r_sampled <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_action  <= i_action;
            r_in_start   <= i_seg_start;
            r_in_end     <= i_seg_end;
            r_in_angle   <= i_sample_angle;
            r_in_last    <= i_last_sample;
            r_res_status <= lasm_pkg::ST_OK;
            r_res_mbit   <= 1'b0;
            r_res_done   <= 1'b0;
            r_res_count  <= '0;
        end
        if (i_cmd.push_commit && !push_ok) begin
            r_res_status <= lasm_pkg::ST_INVALID;
        end
        if (i_cmd.refuse) begin
            r_res_status <= lasm_pkg::ST_ORDER;
        end
        if (i_cmd.sample_eval) begin
            r_res_mbit <= hit;
        end
        if (i_cmd.div_init) begin
            r_res_done  <= 1'b1;
            r_res_count <= r_masked;
            r_rem       <= r_masked;
            r_den       <= r_sampled;
            r_quo       <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? lasm_pkg::TALLY_W'(div_t - {1'b0, r_den})
                            : div_t[lasm_pkg::TALLY_W-1:0];
            r_quo <= {r_quo[lasm_pkg::RATIO_W-2:0], div_ge};
        end
        if (i_cmd.emit) begin
            o_status       <= r_res_status;
            o_mask_bit     <= r_res_mbit;
            o_scan_done    <= r_res_done;
            o_masked_count <= r_res_count;
            o_mask_ratio   <= (r_res_done && (r_den != '0)) ? r_quo : '0;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_count <= lasm_pkg::SEG_CNT_W'(lasm_pkg::MAX_SEGMENTS))
        else $error("segment count above table size");
    a_tally_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_masked <= r_sampled)
        else $error("masked tally exceeds sample tally");
    a_idle_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_scan |-> (r_sampled == '0) && (r_masked == '0) && (r_ptr == '0))
        else $error("scan state left over outside a scan");
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ptr == '0) || ptr_valid)
        else $error("segment pointer beyond table");
`endif

endmodule

`default_nettype wire

[rtl/core/lasm_controller.sv]
// Controller of the lidar angle segment mask: the sequencing state machine,
// the input stall and the output valid register.
// Depends on lasm_pkg; drives lasm_datapath through t_dp_cmd.
`default_nettype none

module lasm_controller (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    input  wire lasm_pkg::t_dp_status i_sts,
    output lasm_pkg::t_dp_cmd         o_cmd
);

    lasm_pkg::t_state r_state;
    lasm_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lasm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_stall     = 1'b1;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            lasm_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lasm_pkg::S_DECODE;
                end
            end
            lasm_pkg::S_DECODE: begin
                case (i_sts.action)
                    lasm_pkg::ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = lasm_pkg::S_FINISH;
                    end
                    lasm_pkg::ACT_PUSH: begin
                        o_cmd.rd_prev = 1'b1;
                        n_state       = lasm_pkg::S_PUSH_EVAL;
                    end
                    lasm_pkg::ACT_SAMPLE: begin
                        if (!i_sts.ordered) begin
                            o_cmd.refuse = 1'b1;
                            n_state      = lasm_pkg::S_FINISH;
                        end else begin
                            o_cmd.sample_read = 1'b1;
                            n_state           = lasm_pkg::S_SAMPLE_EVAL;
                        end
                    end
                    default: begin
                        n_state = lasm_pkg::S_FINISH;
                    end
                endcase
            end
            lasm_pkg::S_PUSH_EVAL: begin
                o_cmd.push_commit = 1'b1;
                n_state           = lasm_pkg::S_FINISH;
            end
            lasm_pkg::S_SAMPLE_EVAL: begin
                o_cmd.sample_eval = 1'b1;
                if (i_sts.last) begin
                    n_state = lasm_pkg::S_DIV_START;
                end else if (i_sts.need_search) begin
                    o_cmd.search_init = 1'b1;
                    n_state           = lasm_pkg::S_SEARCH_RD;
                end else begin
                    n_state = lasm_pkg::S_FINISH;
                end
            end
            lasm_pkg::S_SEARCH_RD: begin
                if (i_sts.k_end) begin
                    o_cmd.set_nomore = 1'b1;
                    n_state          = lasm_pkg::S_FINISH;
                end else begin
                    o_cmd.rd_k = 1'b1;
                    n_state    = lasm_pkg::S_SEARCH_CMP;
                end
            end
            lasm_pkg::S_SEARCH_CMP: begin
                if (i_sts.probe_hit) begin
                    o_cmd.take_k = 1'b1;
                    n_state      = lasm_pkg::S_FINISH;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = lasm_pkg::S_SEARCH_RD;
                end
            end
            lasm_pkg::S_DIV_START: begin
                o_cmd.div_init = 1'b1;
                n_state        = lasm_pkg::S_DIV;
            end
            lasm_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = lasm_pkg::S_FINISH;
                end
            end
            lasm_pkg::S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = lasm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lasm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/lasm_checker.sv]
// Scoreboard for lidar_angle_segment_mask_top: follows window writes and item
// transfers, predicts every result and compares it field by field with the output.
// Depends on lasm_pkg.

module lasm_checker (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    input  wire logic                                    o_stall,
    input  wire logic [lasm_pkg::ACTION_W-1:0]           i_action,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_seg_start,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_seg_end,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_sample_angle,
    input  wire logic                                    i_last_sample,
    input  wire logic                                    o_valid,
    input  wire logic                                    i_stall,
    input  wire logic [lasm_pkg::STATUS_W-1:0]           o_status,
    input  wire logic                                    o_mask_bit,
    input  wire logic                                    o_scan_done,
    input  wire logic [lasm_pkg::TALLY_W-1:0]            o_masked_count,
    input  wire logic [lasm_pkg::RATIO_W-1:0]            o_mask_ratio,
    input  wire logic                                    i_cfg_valid,
    input  wire logic                                    o_cfg_ready,
    input  wire logic [lasm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic signed [lasm_pkg::ANGLE_BITS-1:0]  i_cfg_data,
    output int                                           o_fail_count,
    output int                                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [lasm_pkg::ANGLE_BITS-1:0] t_angle;

    typedef struct packed {
        logic [lasm_pkg::STATUS_W-1:0] status;
        logic                          mask_bit;
        logic                          scan_done;
        logic [lasm_pkg::TALLY_W-1:0]  masked_count;
        logic [lasm_pkg::RATIO_W-1:0]  mask_ratio;
    } t_mask_result;

    t_angle       seg_starts [lasm_pkg::MAX_SEGMENTS];
    t_angle       seg_ends [lasm_pkg::MAX_SEGMENTS];
    int           seg_count;
    int           cur_seg;
    int           masked_tally;
    int           sample_tally;
    bit           table_ordered;
    bit           no_more;
    bit           in_scan;
    t_angle       win_min;
    t_angle       win_max;
    t_mask_result expected_q[$];

    function automatic void drop_scan();
        in_scan = 1'b0;
        cur_seg = 0;
        no_more = 1'b0;
        masked_tally = 0;
        sample_tally = 0;
    endfunction

    function automatic t_mask_result mask_step(logic [lasm_pkg::ACTION_W-1:0] act, t_angle s,
                                               t_angle e, t_angle a, logic last);
        t_mask_result r;
        logic         hit;
        int           k;
        r = '0;
        hit = 1'b0;
        case (act)
            lasm_pkg::ACT_CLEAR: begin
                seg_count = 0;
                table_ordered = 1'b1;
                drop_scan();
            end
            lasm_pkg::ACT_PUSH: begin
                if (s > e || s < win_min || e > win_max
                    || seg_count >= lasm_pkg::MAX_SEGMENTS) begin
                    r.status = lasm_pkg::ST_INVALID;
                end else begin
                    if (seg_count > 0 && seg_ends[seg_count-1] > s) begin
                        table_ordered = 1'b0;
                    end
                    seg_starts[seg_count] = s;
                    seg_ends[seg_count] = e;
                    seg_count++;
                end
            end
            lasm_pkg::ACT_SAMPLE: begin
                if (!table_ordered) begin
                    r.status = lasm_pkg::ST_ORDER;
                    if (last) begin
                        drop_scan();
                    end
                end else begin
                    if (!in_scan) begin
                        drop_scan();
                        in_scan = 1'b1;
                    end
                    if (cur_seg < seg_count) begin
                        hit = (a >= seg_starts[cur_seg]) && (a <= seg_ends[cur_seg]);
                        if (!no_more && a > seg_ends[cur_seg]) begin
                            k = cur_seg;
                            while (k < seg_count && seg_starts[k] < a) begin
                                k++;
                            end
                            if (k < seg_count) begin
                                cur_seg = k;
                            end else begin
                                no_more = 1'b1;
                            end
                        end
                    end
                    r.mask_bit = hit;
                    if (sample_tally < lasm_pkg::MAX_SCAN_SAMPLES) begin
                        sample_tally++;
                        if (hit) begin
                            masked_tally++;
                        end
                    end
                    if (last) begin
                        r.scan_done = 1'b1;
                        r.masked_count = lasm_pkg::TALLY_W'(masked_tally);
                        r.mask_ratio = lasm_pkg::RATIO_W'(
                            (masked_tally << lasm_pkg::RATIO_FRAC) / sample_tally);
                        drop_scan();
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_mask_result want;
        if (!i_rst_n) begin
            seg_count = 0;
            table_ordered = 1'b1;
            drop_scan();
            win_min = lasm_pkg::WIN_MIN_RST;
            win_max = lasm_pkg::WIN_MAX_RST;
            expected_q.delete();
            o_pending = 0;
            o_fail_count = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("Result transfer arrived with no item outstanding.");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("mask_bit", want.mask_bit, o_mask_bit);
                    check_field("scan_done", want.scan_done, o_scan_done);
                    check_field("masked_count", want.masked_count, o_masked_count);
                    check_field("mask_ratio", want.mask_ratio, o_mask_ratio);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lasm_pkg::CFG_WIN_MIN: win_min = i_cfg_data;
                    lasm_pkg::CFG_WIN_MAX: win_max = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_valid && !o_stall) begin
                expected_q.insert(expected_q.size(),
                                  mask_step(i_action, i_seg_start, i_seg_end,
                                            i_sample_angle, i_last_sample));
            end
            o_pending = expected_q.size();
        end
    end

endmodule

[tb/tb_lidar_angle_segment_mask_top.sv]
// Testbench top for lidar_angle_segment_mask_top: clock, reset, window writes,
// directed and random item transfers under random idling, and the verdict.
// Depends on lasm_pkg, the block's RTL and lasm_checker.

module tb_lidar_angle_segment_mask_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [lasm_pkg::ANGLE_BITS-1:0] t_angle;

    localparam logic [lasm_pkg::ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int ANGLE_LO      = lasm_pkg::WIN_MIN_RST;
    localparam int ANGLE_HI      = lasm_pkg::WIN_MAX_RST;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 200;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_valid = 1'b0;
    logic                             o_stall;
    logic [lasm_pkg::ACTION_W-1:0]    i_action = lasm_pkg::ACT_CLEAR;
    t_angle                           i_seg_start = '0;
    t_angle                           i_seg_end = '0;
    t_angle                           i_sample_angle = '0;
    logic                             i_last_sample = 1'b0;
    logic                             o_valid;
    logic                             i_stall = 1'b0;
    logic [lasm_pkg::STATUS_W-1:0]    o_status;
    logic                             o_mask_bit;
    logic                             o_scan_done;
    logic [lasm_pkg::TALLY_W-1:0]     o_masked_count;
    logic [lasm_pkg::RATIO_W-1:0]     o_mask_ratio;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [lasm_pkg::CFG_IDX_W-1:0]   i_cfg_index = lasm_pkg::CFG_WIN_MIN;
    t_angle                           i_cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 27;
    int recv_stall_pct = 52;
    int item_count = 0;
    int cycle_count = 0;
    int win_lo = ANGLE_LO;
    int win_hi = ANGLE_HI;

    lidar_angle_segment_mask_top dut (.*);

    lasm_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_seg_start    (i_seg_start),
        .i_seg_end      (i_seg_end),
        .i_sample_angle (i_sample_angle),
        .i_last_sample  (i_last_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_mask_bit     (o_mask_bit),
        .o_scan_done    (o_scan_done),
        .o_masked_count (o_masked_count),
        .o_mask_ratio   (o_mask_ratio),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int clamp_angle(int v);
        return (v < ANGLE_LO) ? ANGLE_LO : ((v > ANGLE_HI) ? ANGLE_HI : v);
    endfunction

    task automatic send_item(logic [lasm_pkg::ACTION_W-1:0] act, int s, int e, int a,
                             logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_seg_start <= t_angle'(s);
        i_seg_end <= t_angle'(e);
        i_sample_angle <= t_angle'(a);
        i_last_sample <= last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        if (act != ACT_NONE) begin
            item_count++;
        end
    endtask

    task automatic clear_table();
        send_item(lasm_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic push_seg(int s, int e);
        send_item(lasm_pkg::ACT_PUSH, s, e, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic sample_at(int a, logic last);
        send_item(lasm_pkg::ACT_SAMPLE, $urandom, $urandom, a, last);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lasm_pkg::CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= t_angle'(val);
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_window(int lo, int hi);
        wait_results();
        write_reg(lasm_pkg::CFG_WIN_MIN, lo);
        write_reg(lasm_pkg::CFG_WIN_MAX, hi);
        win_lo = lo;
        win_hi = hi;
    endtask

    // One table of mostly ordered segments, mostly inside the window, then one scan over it.
    task automatic run_scan_set();
        int n_seg;
        int n_smp;
        int span;
        int pos;
        int s;
        int e;
        int a;
        int roll;
        int i;
        int j;
        n_seg = ($urandom_range(0, 9) == 0)
              ? $urandom_range(lasm_pkg::MAX_SEGMENTS - 2, lasm_pkg::MAX_SEGMENTS + 2)
              : $urandom_range(0, 6);
        span = win_hi - win_lo;
        pos = win_lo;
        clear_table();
        for (i = 0; i < n_seg; i++) begin
            s = pos + int'($urandom_range(0, span / (n_seg + 1)));
            e = s + int'($urandom_range(0, span / (2 * n_seg + 2)));
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                s = s - int'($urandom_range(1, 2000));
            end else if (roll == 1) begin
                a = s;
                s = e + 1;
                e = a;
            end
            push_seg(clamp_angle(s), clamp_angle(e));
            pos = clamp_angle(e);
        end
        n_smp = $urandom_range(1, 14);
        a = win_lo - int'($urandom_range(0, 600));
        for (j = 0; j < n_smp; j++) begin
            a = clamp_angle(a + int'($urandom_range(0, span / n_smp + 1)));
            if ($urandom_range(0, 29) == 0) begin
                push_seg(a, clamp_angle(a + int'($urandom_range(0, 300))));
            end
            sample_at(a, (j == n_smp - 1) && ($urandom_range(0, 19) != 0));
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            send_item(lasm_pkg::ACTION_W'($urandom_range(lasm_pkg::ACT_CLEAR, ACT_NONE)),
                      $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int mode;
        int sub;
        int lo;
        int hi;
        int target;
        int send_pcts[3];
        int recv_pcts[3];
        send_pcts = '{27, 52, 0};
        recv_pcts = '{52, 27, 0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_window(ANGLE_LO, ANGLE_HI);
        sample_at(0, 1'b1);
        push_seg(ANGLE_LO, ANGLE_LO);
        push_seg(-100, 100);
        push_seg(ANGLE_HI, ANGLE_HI);
        push_seg(200, 100);
        sample_at(ANGLE_LO, 1'b0);
        sample_at(ANGLE_LO + 1, 1'b0);
        sample_at(100, 1'b0);
        sample_at(101, 1'b0);
        sample_at(ANGLE_HI, 1'b1);
        // The first sample exhausts the table; the next one is still tested against segment 0.
        clear_table();
        push_seg(0, 10);
        push_seg(20, 30);
        sample_at(25, 1'b0);
        sample_at(5, 1'b1);
        push_seg(5, 40);
        sample_at(0, 1'b0);
        sample_at(0, 1'b1);
        send_item(ACT_NONE, $urandom, $urandom, $urandom, 1'b1);
        clear_table();
        push_seg(0, 10);
        sample_at(5, 1'b0);
        push_seg(20, 30);
        sample_at(25, 1'b1);
        set_window(-1000, 1000);
        push_seg(-1001, 0);
        push_seg(0, 1001);
        push_seg(-1000, 1000);
        set_window(100, -100);
        push_seg(0, 0);

        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct = send_pcts[mode];
            recv_stall_pct = recv_pcts[mode];
            for (sub = 0; sub < 2; sub++) begin
                lo = -int'($urandom_range(0, 32768));
                hi = int'($urandom_range(0, 32767));
                if (sub == 1) begin
                    if (mode == 0) begin
                        lo = ANGLE_LO;
                        hi = ANGLE_HI;
                    end else if (mode == 1) begin
                        hi = lo;
                    end else begin
                        lo = ANGLE_LO + int'($urandom_range(0, 64000));
                        hi = lo + int'($urandom_range(0, 700));
                    end
                end
                set_window(lo, hi);
                target = item_count + PHASE_ITEMS;
                while (item_count < target) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_noise();
                    end else begin
                        run_scan_set();
                    end
                end
            end
        end

        wait_results();
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/lasm_pkg.sv
rtl/core/lasm_datapath.sv
rtl/core/lasm_controller.sv
rtl/core/lidar_angle_segment_mask_top.sv
tb/lasm_checker.sv
tb/tb_lidar_angle_segment_mask_top.sv
